// ===== hw/rtl/rsfd_pkg.sv =====
package rsfd_pkg;

    // Largest frame dimension the decoder honours; larger settings are clamped.
    localparam int unsigned MAX_DIM = 2048;

    localparam int unsigned DIM_W      = 12;
    localparam int unsigned PIX_W      = 11;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    // Coordinates saturate at the largest 12-bit value.
    localparam logic [DIM_W-1:0] COORD_MAX = {DIM_W{1'b1}};

    // Command byte codes.
    localparam logic [7:0] CMD_EOL   = 8'h80;
    localparam logic [6:0] CMD_COUNT = 7'h7F;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_DOWN     = 2'd2;

    // Queue between the classifier and the executor.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_NOP,
        OP_LITERAL,
        OP_EOL,
        OP_SKIP
    } op_kind_t;

    // One classified request travelling from the front to the back.
    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
        logic       last;
    } op_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             top_down;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{width: 12'd256, height: 12'd256, top_down: 1'b0};

    // Queue status seen by the top level and the executor.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Clamp a dimension to MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W:0] lim;
        begin
            lim = (DIM_W+1)'(MAX_DIM);
            eff_dim = ({1'b0, v} > lim) ? lim[DIM_W-1:0] : v;
        end
    endfunction

    // Saturating coordinate add.
    function automatic logic [DIM_W-1:0] sat_add(input logic [DIM_W-1:0] a,
                                                 input logic [DIM_W-1:0] b);
        logic [DIM_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[DIM_W] ? COORD_MAX : s[DIM_W-1:0];
        end
    endfunction

    // Row at which a frame starts.
    function automatic logic [DIM_W-1:0] start_row(input cfg_t c);
        logic [DIM_W-1:0] h;
        begin
            h = eff_dim(c.height);
            if (c.top_down || h == '0) begin
                start_row = '0;
            end else begin
                start_row = h - 1'b1;
            end
        end
    endfunction

    // A bottom-up frame of no height starts already below row zero.
    function automatic logic start_below(input cfg_t c);
        start_below = !c.top_down && (eff_dim(c.height) == '0);
    endfunction

endpackage

// ===== hw/rtl/rle_sprite_frame_decoder.sv =====
// A request accepted with the queue empty is stored in the queue, then retired into the output register.
// Throughput: one code byte per cycle while the queue has room; the executor retires
// one queued request a cycle and stalls only while the output register holds a result not yet taken.
// A four-entry queue between classifier and executor absorbs output back-pressure.
// Reset: synchronous, active low aresetn; width and height return to 256, bottom-up,
// decoding starts at column 0 of the bottom row; a write to a known register restarts the frame.
module rle_sprite_frame_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rsfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rsfd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_code_byte,
    input  logic                                s_last_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rsfd_pkg::PIX_W-1:0]          m_pixel_col,
    output logic [rsfd_pkg::PIX_W-1:0]          m_pixel_row,
    output logic [7:0]                          m_color_index,
    output logic                                m_write_valid,
    output logic                                m_frame_end
);

    rsfd_pkg::cfg_t      cfg_reg, cfg_next;
    logic                restart;
    logic                s_accept;
    rsfd_pkg::op_t       front_op, head_op;
    rsfd_pkg::q_status_t q_status;
    logic                q_pop;

    // Configuration decode; a write to a known register restarts the frame.
    always_comb begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                rsfd_pkg::REG_FRAME_WIDTH: begin
                    cfg_next.width = cfg_data;
                    restart        = 1'b1;
                end
                rsfd_pkg::REG_FRAME_HEIGHT: begin
                    cfg_next.height = cfg_data;
                    restart         = 1'b1;
                end
                rsfd_pkg::REG_TOP_DOWN: begin
                    cfg_next.top_down = cfg_data[0];
                    restart           = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= rsfd_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Requests are taken whenever the queue has room.
    assign s_ready  = !q_status.full;
    assign s_accept = s_valid && s_ready;

    rsfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .accept    (s_accept),
        .code_byte (s_code_byte),
        .last_byte (s_last_byte),
        .op        (front_op)
    );

    rsfd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_accept),
        .din     (front_op),
        .pop     (q_pop),
        .dout    (head_op),
        .status  (q_status)
    );

    rsfd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .cfg_next      (cfg_next),
        .restart       (restart),
        .op            (head_op),
        .op_valid      (!q_status.empty),
        .pop           (q_pop),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_pixel_col   (m_pixel_col),
        .m_pixel_row   (m_pixel_row),
        .m_color_index (m_color_index),
        .m_write_valid (m_write_valid),
        .m_frame_end   (m_frame_end)
    );

`ifndef SYNTHESIS
    // A result either writes a pixel or closes the frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_valid |-> m_frame_end)
        else $error("result carries neither a pixel write nor a frame end");

    // A written pixel lies inside the configured width.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_valid |->
            ({1'b0, m_pixel_col} < rsfd_pkg::eff_dim(cfg_reg.width)))
        else $error("pixel written outside the frame width");

    // The executor never retires a request from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("queue popped while empty");

    // No result is presented straight after reset.
    assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== hw/rtl/rsfd_front.sv =====
module rsfd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              restart,
    input  logic              accept,
    input  logic [7:0]        code_byte,
    input  logic              last_byte,
    output rsfd_pkg::op_t     op
);

    logic       in_literal_reg, in_literal_next;
    logic [6:0] run_left_reg, run_left_next;

    // Classify the byte against the literal run state.
    always_comb begin
        in_literal_next = in_literal_reg;
        run_left_next   = run_left_reg;
        op.data         = code_byte;
        op.last         = last_byte;
        op.kind         = rsfd_pkg::OP_NOP;
        if (in_literal_reg) begin
            op.kind       = rsfd_pkg::OP_LITERAL;
            run_left_next = (run_left_reg - 7'd1) & rsfd_pkg::CMD_COUNT;
            if (run_left_next == '0) begin
                in_literal_next = 1'b0;
            end
        end else if (code_byte == rsfd_pkg::CMD_EOL) begin
            op.kind = rsfd_pkg::OP_EOL;
        end else if (code_byte[7]) begin
            op.kind = rsfd_pkg::OP_SKIP;
        end else if (code_byte != 8'd0) begin
            run_left_next   = code_byte[6:0];
            in_literal_next = 1'b1;
        end
        // The last byte of a frame returns the classifier to command mode.
        if (last_byte) begin
            in_literal_next = 1'b0;
            run_left_next   = '0;
        end
    end

    // Literal run state.
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            in_literal_reg <= 1'b0;
            run_left_reg   <= '0;
        end else if (accept) begin
            in_literal_reg <= in_literal_next;
            run_left_reg   <= run_left_next;
        end
    end

endmodule

// ===== hw/rtl/rsfd_queue.sv =====
module rsfd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  rsfd_pkg::op_t         din,
    input  logic                  pop,
    output rsfd_pkg::op_t         dout,
    output rsfd_pkg::q_status_t   status
);

    rsfd_pkg::op_t                    entry_reg [rsfd_pkg::QUEUE_DEPTH];
    logic [rsfd_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [rsfd_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign status.full  = (count_reg == rsfd_pkg::QCNT_W'(rsfd_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign dout         = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hw/rtl/rsfd_back.sv =====
module rsfd_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rsfd_pkg::cfg_t                    cfg,
    input  rsfd_pkg::cfg_t                    cfg_next,
    input  logic                              restart,
    input  rsfd_pkg::op_t                     op,
    input  logic                              op_valid,
    output logic                              pop,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic [rsfd_pkg::PIX_W-1:0]        m_pixel_col,
    output logic [rsfd_pkg::PIX_W-1:0]        m_pixel_row,
    output logic [7:0]                        m_color_index,
    output logic                              m_write_valid,
    output logic                              m_frame_end
);

    logic [rsfd_pkg::DIM_W-1:0] col_reg, col_next;
    logic [rsfd_pkg::DIM_W-1:0] row_reg, row_next;
    logic                       below_reg, below_next;
    logic                       m_valid_reg, m_valid_next;
    logic [rsfd_pkg::PIX_W-1:0] col_out_reg, row_out_reg;
    logic [7:0]                 color_out_reg;
    logic                       wr_out_reg, end_out_reg;
    logic                       in_frame, wr, produce, out_free;

    // Decide whether this request writes a pixel and whether it can retire.
    always_comb begin
        in_frame = !below_reg
                   && (row_reg < rsfd_pkg::eff_dim(cfg.height))
                   && (col_reg < rsfd_pkg::eff_dim(cfg.width));
        wr       = op_valid && (op.kind == rsfd_pkg::OP_LITERAL) && in_frame;
        produce  = wr || (op_valid && op.last);
        out_free = !m_valid_reg || m_ready;
        pop      = op_valid && (!produce || out_free);
    end

    // Position update.
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        below_next = below_reg;
        unique case (op.kind)
            rsfd_pkg::OP_LITERAL: begin
                col_next = rsfd_pkg::sat_add(col_reg, 12'd1);
            end
            rsfd_pkg::OP_EOL: begin
                col_next = '0;
                if (cfg.top_down) begin
                    row_next = rsfd_pkg::sat_add(row_reg, 12'd1);
                end else if (row_reg == '0) begin
                    below_next = 1'b1;
                end else begin
                    row_next = row_reg - 1'b1;
                end
            end
            rsfd_pkg::OP_SKIP: begin
                col_next = rsfd_pkg::sat_add(col_reg, {5'd0, op.data[6:0]});
            end
            rsfd_pkg::OP_NOP: begin
                col_next = col_reg;
            end
            default: begin
                col_next = col_reg;
            end
        endcase
        // The last byte restarts the frame.
        if (op.last) begin
            col_next   = '0;
            row_next   = rsfd_pkg::start_row(cfg);
            below_next = rsfd_pkg::start_below(cfg);
        end
    end

    // Position registers; a configuration write restarts with the new values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= rsfd_pkg::start_row(rsfd_pkg::CFG_RESET);
            below_reg <= rsfd_pkg::start_below(rsfd_pkg::CFG_RESET);
        end else if (restart) begin
            col_reg   <= '0;
            row_reg   <= rsfd_pkg::start_row(cfg_next);
            below_reg <= rsfd_pkg::start_below(cfg_next);
        end else if (pop) begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            below_reg <= below_next;
        end
    end

    // Output register valid.
    always_comb begin
        if (pop && produce) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload; fields are zero when no pixel is written.
    always_ff @(posedge aclk) begin
        if (pop && produce) begin
            col_out_reg   <= wr ? col_reg[rsfd_pkg::PIX_W-1:0] : '0;
            row_out_reg   <= wr ? row_reg[rsfd_pkg::PIX_W-1:0] : '0;
            color_out_reg <= wr ? op.data : 8'd0;
            wr_out_reg    <= wr;
            end_out_reg   <= op.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_col   = col_out_reg;
    assign m_pixel_row   = row_out_reg;
    assign m_color_index = color_out_reg;
    assign m_write_valid = wr_out_reg;
    assign m_frame_end   = end_out_reg;

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_HALF      = 10;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS  = 1250;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned PHASE_ITEMS   = 150;

    // A literal count of zero announces nothing and leaves command mode in place.
    localparam logic [7:0] CMD_EMPTY_RUN = 8'h00;

    // One code byte request as it travels towards the decoder.
    typedef struct {
        logic [7:0] code;
        logic       fin;
    } code_req_t;

    // One result as the decoder presents it.
    typedef struct packed {
        logic [rsfd_pkg::PIX_W-1:0] col;
        logic [rsfd_pkg::PIX_W-1:0] row;
        logic [7:0]                 colour;
        logic                       write;
        logic                       frame_end;
    } pix_result_t;

    typedef enum int unsigned {
        RX_OPEN,
        RX_LIGHT,
        RX_HALF,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [rsfd_pkg::CFG_IDX_W-1:0]  cfg_index = rsfd_pkg::REG_FRAME_WIDTH;
    logic [rsfd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    logic [7:0]                      s_code_byte = '0;
    logic                            s_last_byte = 1'b0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    logic [rsfd_pkg::PIX_W-1:0]      m_pixel_col;
    logic [rsfd_pkg::PIX_W-1:0]      m_pixel_row;
    logic [7:0]                      m_color_index;
    logic                            m_write_valid;
    logic                            m_frame_end;

    // Predictor copy of the registers and the decoding state.
    logic [rsfd_pkg::DIM_W-1:0] cfg_width    = 12'd256;
    logic [rsfd_pkg::DIM_W-1:0] cfg_height   = 12'd256;
    logic                       cfg_top_down = 1'b0;
    logic                       lit_mode;
    logic [6:0]                 lit_left;
    logic [rsfd_pkg::DIM_W-1:0] col_pos;
    logic [rsfd_pkg::DIM_W-1:0] row_pos;
    logic                       below_zero;

    code_req_t   code_stream[$];
    pix_result_t predicted_writes[$];
    int unsigned random_items = 0;
    int unsigned bad_results  = 0;

    // Sender and receiver pacing.
    code_req_t   held;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    rx_mode_t    rx_mode    = RX_OPEN;
    int unsigned rx_left    = 0;
    int unsigned rx_tick    = 0;
    pix_result_t due;

    rle_sprite_frame_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_byte   (s_code_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_col   (m_pixel_col),
        .m_pixel_row   (m_pixel_row),
        .m_color_index (m_color_index),
        .m_write_valid (m_write_valid),
        .m_frame_end   (m_frame_end)
    );

    always begin
        #(CLK_HALF) aclk = ~aclk;
    end

    // Dimensions beyond the largest supported frame are clamped.
    function automatic logic [rsfd_pkg::DIM_W-1:0] clamp_dim(
            input logic [rsfd_pkg::DIM_W-1:0] v);
        return (v > rsfd_pkg::MAX_DIM) ? rsfd_pkg::DIM_W'(rsfd_pkg::MAX_DIM) : v;
    endfunction

    function automatic logic [rsfd_pkg::DIM_W-1:0] add_sat(
            input logic [rsfd_pkg::DIM_W-1:0] a, input int unsigned n);
        int unsigned s;
        s = a + n;
        return (s > rsfd_pkg::COORD_MAX) ? rsfd_pkg::COORD_MAX : rsfd_pkg::DIM_W'(s);
    endfunction

    function automatic code_req_t make_req(input logic [7:0] code, input logic fin);
        code_req_t q;
        q.code = code;
        q.fin  = fin;
        return q;
    endfunction

    // Return the decoding state to the start of a frame.
    function automatic void restart_frame();
        lit_mode   = 1'b0;
        lit_left   = '0;
        col_pos    = '0;
        below_zero = 1'b0;
        if (cfg_top_down) begin
            row_pos = '0;
        end else if (clamp_dim(cfg_height) == '0) begin
            row_pos    = '0;
            below_zero = 1'b1;
        end else begin
            row_pos = clamp_dim(cfg_height) - 1'b1;
        end
    endfunction

    // Decode one code byte and queue the result it causes, if any.
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        pix_result_t r;
        r = '0;
        if (lit_mode) begin
            if (!below_zero && row_pos < clamp_dim(cfg_height)
                    && col_pos < clamp_dim(cfg_width)) begin
                r.write  = 1'b1;
                r.col    = col_pos[rsfd_pkg::PIX_W-1:0];
                r.row    = row_pos[rsfd_pkg::PIX_W-1:0];
                r.colour = b;
            end
            col_pos  = add_sat(col_pos, 1);
            lit_left = lit_left - 1'b1;
            if (lit_left == '0) begin
                lit_mode = 1'b0;
            end
        end else if (b == rsfd_pkg::CMD_EOL) begin
            col_pos = '0;
            if (cfg_top_down) begin
                row_pos = add_sat(row_pos, 1);
            end else if (row_pos == '0) begin
                below_zero = 1'b1;
            end else begin
                row_pos = row_pos - 1'b1;
            end
        end else if (b[7]) begin
            col_pos = add_sat(col_pos, 32'(b[6:0] & rsfd_pkg::CMD_COUNT));
        end else if (b != CMD_EMPTY_RUN) begin
            lit_left = b[6:0];
            lit_mode = 1'b1;
        end
        if (fin) begin
            restart_frame();
        end
        if (r.write || fin) begin
            r.frame_end = fin;
            predicted_writes.insert(predicted_writes.size(), r);
        end
    endfunction

    task automatic flag_result(input string why, input pix_result_t want);
        bad_results++;
        if (bad_results <= MAX_REPORTS) begin
            $display("%0t: %s: expected col %0d row %0d colour %0d write %0b end %0b",
                     $realtime, why, want.col, want.row, want.colour, want.write,
                     want.frame_end);
            $display("    got col %0d row %0d colour %0d write %0b end %0b",
                     m_pixel_col, m_pixel_row, m_color_index, m_write_valid, m_frame_end);
        end
    endtask

    // Sender: bursts of requests separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(held.code, held.fin);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (code_stream.size() > 0) begin
                    held = code_stream.pop_front();
                    s_valid     <= 1'b1;
                    s_code_byte <= held.code;
                    s_last_byte <= held.fin;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 16);
                    end
                    burst_left--;
                    if (burst_left == 0) begin
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 12)
                                                               : $urandom_range(1, 3);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result and stalls on a pattern that changes now and then.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_writes.size() == 0) begin
                    flag_result("result with nothing due", '0);
                end else begin
                    due = predicted_writes.pop_front();
                    if (m_pixel_col !== due.col || m_pixel_row !== due.row
                            || m_color_index !== due.colour || m_write_valid !== due.write
                            || m_frame_end !== due.frame_end) begin
                        flag_result("result mismatch", due);
                    end
                end
            end
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 4));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:  m_ready <= 1'b1;
                RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
                RX_HALF:  m_ready <= ($urandom_range(0, 1) != 0);
                RX_HEAVY: m_ready <= ($urandom_range(0, 3) == 0);
                default:  m_ready <= (rx_tick % 5 == 0);
            endcase
        end
    end

    // Wait until every request has been taken and every result has arrived.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (code_stream.size() != 0 || s_valid || predicted_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [rsfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rsfd_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            rsfd_pkg::REG_FRAME_WIDTH:  cfg_width    = val;
            rsfd_pkg::REG_FRAME_HEIGHT: cfg_height   = val;
            rsfd_pkg::REG_TOP_DOWN:     cfg_top_down = val[0];
            default: ;
        endcase
        restart_frame();
    endtask

    task automatic apply_settings(input int unsigned w, input int unsigned h, input bit td);
        wait_drained();
        write_reg(rsfd_pkg::REG_FRAME_WIDTH, rsfd_pkg::CFG_DATA_W'(w));
        write_reg(rsfd_pkg::REG_FRAME_HEIGHT, rsfd_pkg::CFG_DATA_W'(h));
        // Only the lowest bit of the direction register counts.
        write_reg(rsfd_pkg::REG_TOP_DOWN, {(rsfd_pkg::CFG_DATA_W-1)'($urandom), td});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_code(input logic [7:0] code, input logic fin);
        code_stream.insert(code_stream.size(), make_req(code, fin));
    endtask

    task automatic push_repeat(input logic [7:0] code, input int unsigned count);
        repeat (count) push_code(code, 1'b0);
    endtask

    function automatic int unsigned pick_dim(input bit shallow);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            case ($urandom_range(0, 3))
                0:       return 0;
                1:       return 1;
                2:       return rsfd_pkg::MAX_DIM;
                default: return $urandom_range(rsfd_pkg::MAX_DIM + 1, 4095);
            endcase
        end
        if (shallow && roll < 6) return $urandom_range(1, 6);
        if (roll < 5) return $urandom_range(1, 24);
        if (roll < 9) return $urandom_range(1, 300);
        return $urandom_range(1, rsfd_pkg::MAX_DIM);
    endfunction

    // Build a frame of lines made of skips and literal runs, with the odd stray byte.
    // A few frames are cut short, some in the middle of a literal run.
    task automatic add_random_frame(input bit end_marked);
        code_req_t   frame[$];
        int unsigned lines;
        int unsigned segs;
        int unsigned n;
        int unsigned roll;
        int unsigned keep;
        lines = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 8);
        for (int l = 0; l < lines; l++) begin
            segs = $urandom_range(0, 4);
            for (int s = 0; s < segs; s++) begin
                roll = $urandom_range(0, 19);
                if (roll < 9) begin
                    n = $urandom_range(0, 19);
                    if (n < 14) n = $urandom_range(1, 8);
                    else if (n < 19) n = $urandom_range(9, 40);
                    else n = $urandom_range(41, 127);
                    frame.insert(frame.size(), make_req({1'b0, 7'(n)}, 1'b0));
                    repeat (n) frame.insert(frame.size(), make_req(8'($urandom), 1'b0));
                end else if (roll < 15) begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 127)
                                                    : $urandom_range(1, 12);
                    frame.insert(frame.size(), make_req({1'b1, 7'(n)}, 1'b0));
                end else if (roll == 15) begin
                    frame.insert(frame.size(), make_req(CMD_EMPTY_RUN, 1'b0));
                end else if (roll == 16) begin
                    frame.insert(frame.size(), make_req(8'($urandom), 1'b0));
                end
            end
            if (l + 1 < lines || $urandom_range(0, 1) == 0) begin
                frame.insert(frame.size(), make_req(rsfd_pkg::CMD_EOL, 1'b0));
            end
        end
        if ($urandom_range(0, 9) == 0 && frame.size() > 1) begin
            keep  = $urandom_range(1, frame.size() - 1);
            frame = frame[0:keep-1];
        end
        if (frame.size() == 0) begin
            frame.insert(frame.size(), make_req(rsfd_pkg::CMD_EOL, 1'b0));
        end
        if (end_marked) begin
            frame[frame.size()-1].fin = 1'b1;
        end
        foreach (frame[i]) code_stream.insert(code_stream.size(), frame[i]);
        random_items += frame.size();
    endtask

    initial begin
        int unsigned phase_start;

        restart_frame();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: zero count, literals at the byte extremes, skips,
        // a literal that looks like an end of line, and last bytes of every kind.
        push_code(CMD_EMPTY_RUN, 1'b0);
        push_code(8'h02, 1'b0);
        push_code(8'hFF, 1'b0);
        push_code(8'h00, 1'b0);
        push_code(8'hFF, 1'b0);
        push_code(8'h81, 1'b0);
        push_code(8'h01, 1'b0);
        push_code(rsfd_pkg::CMD_EOL, 1'b0);
        push_code(rsfd_pkg::CMD_EOL, 1'b0);
        push_code(8'h7F, 1'b0);
        push_code(8'hAA, 1'b0);
        push_code(8'h55, 1'b1);
        push_code(rsfd_pkg::CMD_EOL, 1'b1);
        push_code(CMD_EMPTY_RUN, 1'b1);
        push_code(8'hD5, 1'b1);
        push_code(8'h03, 1'b0);
        push_code(8'h5A, 1'b0);
        push_code(8'hA5, 1'b1);

        // Largest frame: the right-hand edge, then the column saturating.
        apply_settings(rsfd_pkg::MAX_DIM, rsfd_pkg::MAX_DIM, 1'b0);
        push_repeat(8'hFF, 16);
        push_code(8'h8F, 1'b0);
        push_code(8'h02, 1'b0);
        push_code(8'h11, 1'b0);
        push_code(8'h22, 1'b0);
        push_repeat(8'hFF, 17);
        push_code(8'h01, 1'b0);
        push_code(8'h33, 1'b0);
        push_code(rsfd_pkg::CMD_EOL, 1'b0);
        push_code(8'h01, 1'b0);
        push_code(8'h44, 1'b1);

        // Single pixel frame: clipping, the row going below zero, and a frame
        // left unfinished for the next register write to abandon.
        apply_settings(1, 1, 1'b0);
        push_code(8'h02, 1'b0);
        push_code(8'h01, 1'b0);
        push_code(8'h02, 1'b0);
        push_code(rsfd_pkg::CMD_EOL, 1'b0);
        push_code(8'h01, 1'b0);
        push_code(8'h03, 1'b0);
        push_code(rsfd_pkg::CMD_EOL, 1'b0);
        push_code(8'h01, 1'b0);
        push_code(8'h04, 1'b1);
        push_code(8'h01, 1'b0);
        push_code(8'h05, 1'b1);
        push_code(8'h03, 1'b0);
        push_code(8'h06, 1'b0);

        // Zero width, then zero height in both directions.
        apply_settings(0, 5, 1'b1);
        push_code(8'h02, 1'b0);
        push_code(8'h07, 1'b0);
        push_code(8'h08, 1'b1);
        apply_settings(4095, 0, 1'b0);
        push_code(8'h01, 1'b0);
        push_code(8'h09, 1'b1);
        apply_settings(10, 0, 1'b1);
        push_code(8'h01, 1'b0);
        push_code(8'h0A, 1'b1);

        // Oversized settings clamp: bottom-up starts on the last clamped row and
        // the column just past the clamped width is clipped; top-down starts at row zero.
        apply_settings(4095, 4095, 1'b0);
        push_code(8'h01, 1'b0);
        push_code(8'h0B, 1'b0);
        push_repeat(8'hFF, 16);
        push_code(8'h8F, 1'b0);
        push_code(8'h01, 1'b0);
        push_code(8'h0C, 1'b0);
        push_code(rsfd_pkg::CMD_EOL, 1'b0);
        push_code(8'h01, 1'b0);
        push_code(8'h0D, 1'b1);
        apply_settings(4095, 4095, 1'b1);
        push_code(8'h01, 1'b0);
        push_code(8'h0E, 1'b0);
        push_code(rsfd_pkg::CMD_EOL, 1'b0);
        push_code(8'h01, 1'b0);
        push_code(8'h0F, 1'b1);

        // Random settings, each with a run of frames and an abandoned tail.
        while (random_items < RANDOM_ITEMS) begin
            apply_settings(pick_dim(1'b0), pick_dim(1'b1), 1'($urandom_range(0, 1)));
            phase_start = random_items;
            while (random_items - phase_start < PHASE_ITEMS) begin
                add_random_frame(1'b1);
            end
            add_random_frame(1'b0);
        end

        wait_drained();
        if (bad_results == 0 && predicted_writes.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
